// ----- rtl/sobel_edge_magnitude_unit_assert.svh -----
// Assertion macros used by the checker of the Sobel edge magnitude unit.
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH

// Implication into the next cycle, switched off while reset is held.
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication into the next cycle that also holds while reset is held.
`define SEM_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sem_pkg.sv -----
// Shared constants, types and state encoding of the Sobel edge magnitude unit.
package sem_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int EW_W      = COL_W + 1;

  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 16;
  localparam int ROW_W      = CFG_H_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = 16'd1024;

  localparam int PIX_W = 24;
  localparam int SUM_W = 21;

  localparam logic       OP_PIXEL = 1'b0;
  localparam logic [SUM_W-1:0] ROOT_CLAMP = 21'd65280;

  typedef struct packed {
    logic       op;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_SQR,
    ST_ROOT,
    ST_DONE
  } sem_state_t;

endpackage

// ----- rtl/sem_in_if.sv -----
// Request channel that carries one input pixel or flush tick.
interface sem_in_if;
  import sem_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sem_out_if.sv -----
// Request channel that carries one Sobel magnitude result.
interface sem_out_if;
  import sem_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sobel_edge_magnitude_unit.sv -----
// Sobel edge magnitude over an RGB raster stream. Pixels enter in raster order (op=0);
// after the last pixel of a frame, image_width+1 flush requests (op=1) drain the last
// row and column. Each input request releases at most one result, the pixel one row and
// one column behind it, carrying round(sqrt(Gx^2+Gy^2)) clamped to 255 per channel, with
// neighbors outside the image taken as zero; frame_end marks the frame's last pixel.
// The two line stores live in one synchronous memory of MAX_WIDTH words of 48 bits,
// read when a request is accepted and written back the next cycle. A request that
// produces a result passes through memory read, window update, gradient sums,
// squaring, an 8-step binary search for the rounded root and the output load. A
// request that produces no result goes back to idle after the window update. The
// output register lets a finished result wait while the next request is taken in.
// Configuration writes must only happen while the block is idle. Line store contents
// after reset are garbage, but those entries are only read at masked-off positions.
module sobel_edge_magnitude_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  sem_in_if.sink                           in_if,
  sem_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sem_pkg::*;

  // Configuration and the effective frame size after clamping.
  logic [CFG_W_W-1:0] cfg_width_r;
  logic [CFG_H_W-1:0] cfg_height_r;
  logic [EW_W-1:0]    eff_w;
  logic [CFG_H_W-1:0] eff_h;

  // Raster position of the next request.
  logic [COL_W-1:0] col_r, col_nxt, col_n;
  logic [ROW_W-1:0] row_r, row_nxt, row_n;
  logic [ROW_W-1:0] h_ext, h_p1, crow;
  logic [EW_W-1:0]  col_ext;
  logic             pos_reset, last_col, row_ok, emit;
  logic             top, bot, left, right, frame_end;

  // Per-request values held while the request works through the datapath.
  logic [PIX_W-1:0] pix_q;
  logic [COL_W-1:0] col_q;
  logic             emit_q, top_q, bot_q, left_q, right_q, fe_q;

  // Line store memory: upper row in the high half, middle row in the low half.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  // 3x3 window, index row*3+col, column 2 is the newest.
  logic [PIX_W-1:0] win_r [9];

  // Gradient, square and root datapath, one lane per color channel.
  logic                    keep [9];
  logic [7:0]              pv [3][9];
  logic [9:0]              gx_pos [3], gx_neg [3], gy_pos [3], gy_neg [3];
  logic signed [10:0]      gx_nxt [3], gy_nxt [3];
  logic signed [10:0]      gx_r [3], gy_r [3];
  logic signed [21:0]      gx_sq [3], gy_sq [3];
  logic [SUM_W-1:0]        sum_nxt [3];
  logic [SUM_W-1:0]        sum_r [3];
  logic [7:0]              lo_r [3], hi_r [3];
  logic [7:0]              lo_nxt [3], hi_nxt [3];
  logic [8:0]              mid_sum [3];
  logic [7:0]              mid [3];
  logic [15:0]             mid_sq [3];
  logic [15:0]             f_mid [3];
  logic [2:0]              step_r;

  // Control.
  sem_state_t state_r, state_nxt;
  logic       accept, out_free, out_load, mem_we;
  logic       out_valid_r;
  out_item_t  out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data[CFG_W_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_data[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // A width of zero acts as one and anything above the line store depth as the depth.
  always_comb begin
    if (cfg_width_r == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(cfg_width_r);
    end
    eff_h = (cfg_height_r == '0) ? CFG_H_W'(1) : cfg_height_r;
  end

  // Position bookkeeping for the request being accepted. The center pixel whose
  // result this request releases sits one row and one column back; at column zero
  // that is the last column of the row two back.
  always_comb begin
    h_ext   = {1'b0, eff_h};
    h_p1    = h_ext + ROW_W'(1);
    // A configuration change can leave the position outside the frame and its
    // drain, in which case the stream restarts at the first pixel.
    pos_reset = (EW_W'(col_r) >= eff_w) || (row_r > h_p1) ||
                ((row_r == h_p1) && (col_r != '0));
    col_n   = pos_reset ? '0 : col_r;
    row_n   = pos_reset ? '0 : row_r;
    col_ext = EW_W'(col_n);
    last_col = (col_ext + EW_W'(1)) >= eff_w;

    if (col_n != '0) begin
      row_ok = (row_n >= ROW_W'(1));
      crow   = row_n - ROW_W'(1);
      left   = (col_n == COL_W'(1));
      right  = 1'b0;
    end else begin
      row_ok = (row_n >= ROW_W'(2));
      crow   = row_n - ROW_W'(2);
      left   = (eff_w == EW_W'(1));
      right  = 1'b1;
    end
    emit      = row_ok && (crow < h_ext);
    top       = (crow == '0);
    bot       = (crow == (h_ext - ROW_W'(1)));
    frame_end = bot && right;

    // The frame's last result rewinds the position to the start of the next frame.
    if (emit && frame_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (last_col) begin
      col_nxt = '0;
      row_nxt = row_n + ROW_W'(1);
    end else begin
      col_nxt = col_n + COL_W'(1);
      row_nxt = row_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_q <= 1'b0;
    end else if (accept) begin
      emit_q <= emit;
    end
  end

  // Payload of the accepted request; a flush counts as a black pixel.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_q   <= (in_if.data.op == OP_PIXEL) ?
                 {in_if.data.in_red, in_if.data.in_green, in_if.data.in_blue} : '0;
      col_q   <= col_n;
      top_q   <= top;
      bot_q   <= bot;
      left_q  <= left;
      right_q <= right;
      fe_q    <= frame_end;
    end
  end

  // Read at acceptance, write back the shifted column in the cycle after. Only one
  // request is in flight, so a read never overlaps a pending write to the same word.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= line_mem[col_n];
    end
    if (mem_we) begin
      line_mem[col_q] <= {rd_q[PIX_W-1:0], pix_q};
    end
  end

  // Window shift: every row moves one column left and the new column comes from
  // the line stores and the incoming pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (mem_we) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]     <= win_r[r*3+1];
        win_r[r*3 + 1] <= win_r[r*3+2];
      end
      win_r[2] <= rd_q[2*PIX_W-1:PIX_W];
      win_r[5] <= rd_q[PIX_W-1:0];
      win_r[8] <= pix_q;
    end
  end

  // Gradient sums with neighbors outside the image masked to zero.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        keep[r*3+c] = !((r == 0) && top_q) && !((r == 2) && bot_q) &&
                      !((c == 0) && left_q) && !((c == 2) && right_q);
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        pv[ch][i] = keep[i] ? win_r[i][(2-ch)*8 +: 8] : 8'd0;
      end
      gx_pos[ch] = 10'(pv[ch][2]) + {1'b0, pv[ch][5], 1'b0} + 10'(pv[ch][8]);
      gx_neg[ch] = 10'(pv[ch][0]) + {1'b0, pv[ch][3], 1'b0} + 10'(pv[ch][6]);
      gy_pos[ch] = 10'(pv[ch][6]) + {1'b0, pv[ch][7], 1'b0} + 10'(pv[ch][8]);
      gy_neg[ch] = 10'(pv[ch][0]) + {1'b0, pv[ch][1], 1'b0} + 10'(pv[ch][2]);
      gx_nxt[ch] = $signed({1'b0, gx_pos[ch]}) - $signed({1'b0, gx_neg[ch]});
      gy_nxt[ch] = $signed({1'b0, gy_pos[ch]}) - $signed({1'b0, gy_neg[ch]});
      gx_sq[ch]  = gx_r[ch] * gx_r[ch];
      gy_sq[ch]  = gy_r[ch] * gy_r[ch];
      sum_nxt[ch] = SUM_W'(gx_sq[ch]) + SUM_W'(gy_sq[ch]);
    end
  end

  // One binary-search step per cycle: the rounded root is the least r with
  // r*r + r >= s. Sums above the clamp start with lo = hi = 255 and stay there.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mid_sum[ch] = {1'b0, lo_r[ch]} + {1'b0, hi_r[ch]};
      mid[ch]     = mid_sum[ch][8:1];
      mid_sq[ch]  = mid[ch] * mid[ch];
      f_mid[ch]   = mid_sq[ch] + 16'(mid[ch]);
      lo_nxt[ch]  = lo_r[ch];
      hi_nxt[ch]  = hi_r[ch];
      if (lo_r[ch] < hi_r[ch]) begin
        if (SUM_W'(f_mid[ch]) >= sum_r[ch]) begin
          hi_nxt[ch] = mid[ch];
        end else begin
          lo_nxt[ch] = mid[ch] + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (state_r == ST_SUM) begin
        gx_r[ch] <= gx_nxt[ch];
        gy_r[ch] <= gy_nxt[ch];
      end
      if (state_r == ST_SQR) begin
        sum_r[ch] <= sum_nxt[ch];
        lo_r[ch]  <= (sum_nxt[ch] > ROOT_CLAMP) ? 8'd255 : 8'd0;
        hi_r[ch]  <= 8'd255;
      end else if (state_r == ST_ROOT) begin
        lo_r[ch]  <= lo_nxt[ch];
        hi_r[ch]  <= hi_nxt[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (state_r == ST_ROOT) begin
      step_r <= step_r + 3'd1;
    end else begin
      step_r <= '0;
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_if.valid) begin
        state_nxt = ST_READ;
      end
      ST_READ: state_nxt = emit_q ? ST_SUM : ST_IDLE;
      ST_SUM:  state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_ROOT;
      ST_ROOT: if (step_r == '1) begin
        state_nxt = ST_DONE;
      end
      ST_DONE: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    out_free    = !out_valid_r || out_if.ready;
    in_if.ready = (state_r == ST_IDLE);
    accept      = in_if.ready && in_if.valid;
    mem_we      = (state_r == ST_READ);
    out_load    = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.out_red   <= lo_r[0];
      out_data_r.out_green <= lo_r[1];
      out_data_r.out_blue  <= lo_r[2];
      out_data_r.frame_end <= fe_q;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

endmodule

// ----- rtl/sem_checker.sv -----
// Port-level checks of the Sobel edge magnitude unit and their binding.
`include "sobel_edge_magnitude_unit_assert.svh"

module sem_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sem_pkg::out_item_t out_data
);
  import sem_pkg::*;

  // Reset leaves no result pending.
  `SEM_ASSERT_ALWAYS_NEXT(a_reset_empties_output, !rst_n, !out_valid, "result pending after reset")

  // The block works on one request at a time.
  `SEM_ASSERT_NEXT(a_one_request_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")

  // A result needs at least the memory read before it can appear.
  `SEM_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && !out_valid, !out_valid, "result too early")

  // A stalled result holds its value.
  `SEM_ASSERT_NEXT(a_stalled_result_holds, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind sobel_edge_magnitude_unit sem_checker u_sem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
